// ===== sv/wsc_pkg.sv =====
// ----------------------------------------------------------------------------
// wsc_pkg
// Shared types, constants and the whitespace table for the whitespace collapser.
// ----------------------------------------------------------------------------
package wsc_pkg;

   localparam int NumWs             = 26;
   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] SpaceByte = 8'h20;

   // bit positions inside rsp_tuser
   localparam int UserBytePresent = 0;
   localparam int UserTextEnd     = 1;

   // whitespace sequences, first byte at index 0; unused tail bytes are zero
   localparam logic [7:0] WsSeq [NumWs][3] = '{
      '{8'h09, 8'h00, 8'h00}, '{8'h0A, 8'h00, 8'h00}, '{8'h0B, 8'h00, 8'h00},
      '{8'h0C, 8'h00, 8'h00}, '{8'h0D, 8'h00, 8'h00}, '{8'h20, 8'h00, 8'h00},
      '{8'hC2, 8'h85, 8'h00}, '{8'hC2, 8'hA0, 8'h00},
      '{8'hE1, 8'h9A, 8'h80}, '{8'hE1, 8'hA0, 8'h8E},
      '{8'hE2, 8'h80, 8'h80}, '{8'hE2, 8'h80, 8'h81}, '{8'hE2, 8'h80, 8'h82},
      '{8'hE2, 8'h80, 8'h83}, '{8'hE2, 8'h80, 8'h84}, '{8'hE2, 8'h80, 8'h85},
      '{8'hE2, 8'h80, 8'h86}, '{8'hE2, 8'h80, 8'h87}, '{8'hE2, 8'h80, 8'h88},
      '{8'hE2, 8'h80, 8'h89}, '{8'hE2, 8'h80, 8'h8A}, '{8'hE2, 8'h80, 8'hA8},
      '{8'hE2, 8'h80, 8'hA9}, '{8'hE2, 8'h80, 8'hAF}, '{8'hE2, 8'h81, 8'h9F},
      '{8'hE3, 8'h80, 8'h80}
   };

   localparam logic [1:0] WsLen [NumWs] = '{
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
   };

   typedef enum logic [1:0] {
      ClsNone    = 2'd0,
      ClsPartial = 2'd1,
      ClsFull    = 2'd2
   } cls_type;

   // one record per request: the results that request causes
   typedef struct packed {
      logic             space;     // a collapsed space goes first
      logic [1:0]       cnt;       // text bytes that follow, 0 to 3
      logic [2:0][7:0]  bytes;     // bytes[0] goes out first
      logic             text_end;  // end-of-text result goes last
   } wsc_rec_type;

   // match the first n bytes (1 to 3) of p against the whitespace table
   function automatic cls_type ws_classify(input logic [2:0][7:0] p, input logic [1:0] n);
      cls_type res;
      logic    eq;
      res = ClsNone;
      for (int e = 0; e < NumWs; e++) begin
         eq = (WsLen[e] >= n);
         for (int j = 0; j < 3; j++) begin
            if (j < int'(n) && WsSeq[e][j] != p[j]) begin
               eq = 1'b0;
            end
         end
         if (eq && WsLen[e] == n) begin
            res = ClsFull;
         end else if (eq && res != ClsFull) begin
            res = ClsPartial;
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/wsc_front.sv =====
// ----------------------------------------------------------------------------
// wsc_front
// Takes one byte a cycle while q_full is low, tracks character and
// whitespace-run state and builds the record of results that the byte causes.
// ----------------------------------------------------------------------------
module wsc_front
   import wsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        q_full,
   output logic        push,
   output wsc_rec_type push_rec
);

   logic       inside_ff, inside_in;
   logic       wrote_ff, wrote_in;
   logic [7:0] held_ff [2];
   logic [7:0] held_in [2];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [2:0] left_ff, left_in;

   logic            accept;
   logic            fresh;
   logic [1:0]      n;
   logic [2:0]      remain;
   logic [2:0][7:0] p;
   cls_type         cls;
   wsc_rec_type     rec;

   // bytes still due after a lead byte: leading ones minus one
   function automatic logic [2:0] lead_remain(input logic [7:0] b);
      logic [3:0] ones;
      logic       run;
      ones = '0;
      run  = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            ones = ones + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      if (!b[7]) begin
         return 3'd0;
      end
      return 3'(ones - 4'd1);
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      fresh = (left_ff == 3'd0) || (held_cnt_ff != 2'd0);
      if (left_ff == 3'd0) begin
         n      = 2'd1;
         remain = lead_remain(req_tdata);
      end else begin
         n      = held_cnt_ff + 2'd1;
         remain = left_ff - 3'd1;
      end
      p[0] = (n == 2'd1) ? req_tdata : held_ff[0];
      p[1] = (n == 2'd2) ? req_tdata : held_ff[1];
      p[2] = req_tdata;
      cls  = ws_classify(p, n);

      inside_in   = inside_ff;
      wrote_in    = wrote_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      left_in     = left_ff;
      rec.space    = 1'b0;
      rec.cnt      = 2'd0;
      rec.bytes    = p;
      rec.text_end = req_tlast;

      if (fresh) begin
         if (cls == ClsFull) begin
            inside_in   = 1'b1;
            held_cnt_in = 2'd0;
            left_in     = 3'd0;
         end else if (cls == ClsPartial && !req_tlast && remain != 3'd0 && n != 2'd3) begin
            // still undecided: hold the byte until the next ones settle it
            held_in[n[1]] = req_tdata;
            held_cnt_in   = n;
            left_in       = remain;
         end else begin
            rec.space   = inside_ff && wrote_ff;
            rec.cnt     = n;
            wrote_in    = 1'b1;
            inside_in   = 1'b0;
            held_cnt_in = 2'd0;
            left_in     = remain;
         end
      end else begin
         rec.cnt      = 2'd1;
         rec.bytes[0] = req_tdata;
         left_in      = left_ff - 3'd1;
      end

      if (req_tlast) begin
         inside_in   = 1'b1;
         wrote_in    = 1'b0;
         held_cnt_in = 2'd0;
         left_in     = 3'd0;
      end
   end

   assign push     = accept && (rec.space || rec.cnt != 2'd0 || rec.text_end);
   assign push_rec = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff   <= 1'b1;
         wrote_ff    <= 1'b0;
         held_cnt_ff <= 2'd0;
         left_ff     <= 3'd0;
      end else if (accept) begin
         inside_ff   <= inside_in;
         wrote_ff    <= wrote_in;
         held_cnt_ff <= held_cnt_in;
         left_ff     <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   a_held_needs_more: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff != 2'd0 |-> left_ff != 3'd0)
      else $error("bytes held with no continuation bytes due");

   a_held_cnt_range: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff != 2'd3)
      else $error("more than two bytes held");

endmodule

// ===== sv/wsc_queue.sv =====
// ----------------------------------------------------------------------------
// wsc_queue
// Short record queue between the front and the back end.
// ----------------------------------------------------------------------------
module wsc_queue
   import wsc_pkg::*;
#(
   parameter int Depth = QueueDepthDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  wsc_rec_type push_rec,
   input  logic        pop,
   output logic        q_full,
   output logic        q_valid,
   output wsc_rec_type q_rec
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   wsc_rec_type      mem [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
      return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign q_full  = (count_ff == CntW'(Depth));
   assign q_valid = (count_ff != '0);
   assign q_rec   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("record queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != CntW'(Depth))
      else $error("record queue pushed while full");

endmodule

// ===== sv/wsc_back.sv =====
// ----------------------------------------------------------------------------
// wsc_back
// Unrolls each record into single results and drives the output register.
// ----------------------------------------------------------------------------
module wsc_back
   import wsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  wsc_rec_type q_rec,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   // record being unrolled: one pending bit per result still due
   logic            sp_ff, sp_in;
   logic [2:0]      mask_ff, mask_in;
   logic            end_ff, end_in;
   logic [2:0][7:0] bytes_ff, bytes_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [1:0] rsp_user_ff, rsp_user_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       busy, adv, emit, more;
   logic       sp_clr, end_clr;
   logic [2:0] mask_clr;
   logic [7:0] sel_byte;
   logic       sel_present, sel_end;
   logic [2:0] load_mask;

   always_comb begin
      busy = sp_ff || (mask_ff != 3'b000) || end_ff;
      adv  = !rsp_valid_ff || rsp_tready;
      emit = busy && adv;

      // take the earliest pending result
      sp_clr      = sp_ff;
      mask_clr    = mask_ff;
      end_clr     = end_ff;
      sel_byte    = 8'h00;
      sel_present = 1'b1;
      sel_end     = 1'b0;
      if (sp_ff) begin
         sel_byte = SpaceByte;
         sp_clr   = 1'b0;
      end else if (mask_ff[0]) begin
         sel_byte    = bytes_ff[0];
         mask_clr[0] = 1'b0;
      end else if (mask_ff[1]) begin
         sel_byte    = bytes_ff[1];
         mask_clr[1] = 1'b0;
      end else if (mask_ff[2]) begin
         sel_byte    = bytes_ff[2];
         mask_clr[2] = 1'b0;
      end else begin
         sel_present = 1'b0;
         sel_end     = 1'b1;
         end_clr     = 1'b0;
      end
      more = sp_clr || (mask_clr != 3'b000) || end_clr;

      pop = q_valid && (!busy || (emit && !more));

      case (q_rec.cnt)
         2'd0:    load_mask = 3'b000;
         2'd1:    load_mask = 3'b001;
         2'd2:    load_mask = 3'b011;
         2'd3:    load_mask = 3'b111;
         default: load_mask = 3'b000;
      endcase

      sp_in    = sp_ff;
      mask_in  = mask_ff;
      end_in   = end_ff;
      bytes_in = bytes_ff;
      if (emit) begin
         sp_in   = sp_clr;
         mask_in = mask_clr;
         end_in  = end_clr;
      end
      if (pop) begin
         sp_in    = q_rec.space;
         mask_in  = load_mask;
         end_in   = q_rec.text_end;
         bytes_in = q_rec.bytes;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in                 = 1'b1;
         rsp_byte_in                  = sel_byte;
         rsp_user_in[UserBytePresent] = sel_present;
         rsp_user_in[UserTextEnd]     = sel_end;
         rsp_last_in                  = !more;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= 1'b0;
         mask_ff      <= 3'b000;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         mask_ff      <= mask_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff[UserTextEnd] |-> rsp_last_ff && !rsp_user_ff[UserBytePresent]
         && rsp_byte_ff == 8'h00)
      else $error("end-of-text result is not the last, bare result");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_user_ff[UserBytePresent] != rsp_user_ff[UserTextEnd])
      else $error("result is neither a byte nor an end marker");

endmodule

// ===== sv/utf8_whitespace_collapser_core.sv =====
// ----------------------------------------------------------------------------
// utf8_whitespace_collapser_core
// Collapses Unicode whitespace runs in a UTF-8 byte stream to single spaces.
// ----------------------------------------------------------------------------
// A byte is taken every cycle while req_tready is high; req_tready drops only
// when the record queue between the front end and the output side is full.
// Each byte yields zero to five results (a space, up to two held bytes, the
// byte itself, and the end marker on the last byte), which leave through the
// output register at one per cycle while rsp_tready is high, so a sustained
// rate of one byte per cycle holds as long as bytes average at most one result
// each; the single output port sets the limit beyond that. Results pass the
// queue and the back end's registers. Leading and trailing whitespace never
// leaves the block, and every text ends with one result that has text_end set.
module utf8_whitespace_collapser_core
   import wsc_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] byte_present, [1] text_end
   output logic        rsp_tlast
);

   logic        q_full, q_valid, push, pop;
   wsc_rec_type push_rec, q_rec;

   wsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   wsc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_rec    (q_rec)
   );

   wsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_rec      (q_rec),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
